FILE: rtl/dcmd_pkg.sv
// ----------------------------------------------------------------------------
// DC motor duty and direction package
// Shared widths, command and register codes, and the compare request type.
// ----------------------------------------------------------------------------
package dcmd_pkg;

  localparam int unsigned PeriodWidth  = 16;
  localparam int unsigned DutyWidth    = 15;
  localparam int unsigned MagWidth     = 14;
  localparam int unsigned ProdWidth    = PeriodWidth + MagWidth;
  localparam int unsigned PinWidth     = 6;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam int unsigned DutyFull  = 10000;
  localparam int unsigned RoundHalf = DutyFull / 2;

  // Reciprocal of the full-scale duty: floor(x * RecipMul / 2^RecipShift) equals
  // floor(x / DutyFull) for every x below 2^ProdWidth.
  localparam int unsigned RecipShift = 43;
  localparam int unsigned RecipWidth = 30;
  localparam logic [RecipWidth-1:0] RecipMul = RecipWidth'(879609303);

  localparam int unsigned PinDirFwd   = 0;
  localparam int unsigned PinDirRev   = 1;
  localparam int unsigned PinAuxFwd   = 2;
  localparam int unsigned PinAuxRev   = 3;
  localparam int unsigned PinDirBrake = 4;
  localparam int unsigned PinAuxBrake = 5;

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_SET_DUTY = 2'd1,
    OP_STOP     = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PERIOD      = 3'd0,
    CFG_REVERSE     = 3'd1,
    CFG_BRAKE_EN    = 3'd2,
    CFG_BRAKE_DUTY  = 3'd3,
    CFG_PIN_LEVELS  = 3'd4,
    CFG_AUX_PRESENT = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMP_HOLD = 2'd0,
    CMP_ZERO = 2'd1,
    CMP_LOAD = 2'd2
  } cmp_act_e;

  typedef struct packed {
    cmp_act_e               act;
    logic [ProdWidth-1:0]   scaled;
  } cmp_req_t;

endpackage

FILE: rtl/dcmd_compare_scale.sv
// ----------------------------------------------------------------------------
// Compare scaling
// Divides the rounded duty-period product by the full-scale duty through a
// reciprocal multiply, limits it to the period and picks the next compare.
// ----------------------------------------------------------------------------
module dcmd_compare_scale (
  input  dcmd_pkg::cmp_req_t                 req_i,
  input  logic [dcmd_pkg::PeriodWidth-1:0]   period_i,
  input  logic [dcmd_pkg::PeriodWidth-1:0]   held_i,
  output logic [dcmd_pkg::PeriodWidth-1:0]   compare_o
);
  import dcmd_pkg::*;

  logic [ProdWidth+RecipWidth-1:0] recip_prod;
  logic [PeriodWidth:0]            quot;
  logic [PeriodWidth-1:0]          limited;

  assign recip_prod = (ProdWidth + RecipWidth)'(req_i.scaled)
                    * (ProdWidth + RecipWidth)'(RecipMul);
  assign quot       = recip_prod[RecipShift+PeriodWidth:RecipShift];
  assign limited    = (quot > {1'b0, period_i}) ? period_i : quot[PeriodWidth-1:0];

  always_comb begin
    unique case (req_i.act)
      CMP_ZERO: compare_o = '0;
      CMP_LOAD: compare_o = limited;
      default:  compare_o = held_i;
    endcase
  end

endmodule

FILE: rtl/dc_motor_duty_direction_unit.sv
// ----------------------------------------------------------------------------
// DC motor duty and direction unit
// Turns init, set-duty and stop commands into H-bridge pin levels and a PWM
// compare count.
//
// Commands enter on the slave stream: tuser carries the opcode and tdata the
// signed duty in hundredths of a percent. Every command gives one result on
// the master stream: the compare count, the held direction and aux levels and
// the PWM enable flag. Registers are written over the configuration channel,
// which is always ready, only while no command is in flight; the user must
// keep to this, as the block does not enforce it. The duty-period product
// is formed ahead of the first stage register and is divided by full scale
// through a reciprocal multiply ahead of the output register. One command is
// accepted every cycle while results are taken; on a stall, the result
// and the command behind it hold; the slave stops only once both stages fill.
// Reset clears all registers, the held levels, the compare and the enable.
// ----------------------------------------------------------------------------
module dc_motor_duty_direction_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dcmd_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [dcmd_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // duty[14:0], zero pad
  input  logic [1:0]                          s_axis_tuser,  // opcode[1:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata   // compare[15:0], dir,
                                                             // aux, pwm_enabled
);
  import dcmd_pkg::*;

  logic [PeriodWidth-1:0] period_q;
  logic                   reverse_q;
  logic                   brake_en_q;
  logic [MagWidth-1:0]    brake_duty_q;
  logic [PinWidth-1:0]    pins_q;
  logic                   aux_present_q;

  logic dir_q, dir_d;
  logic aux_q, aux_d;
  logic run_q, run_d;

  logic                   s1_valid_q;
  cmp_req_t               s1_req_q, s1_req_d;
  logic                   s1_dir_q, s1_aux_q, s1_run_q;

  logic                   out_valid_q;
  logic [PeriodWidth-1:0] cmp_q, cmp_d;
  logic                   out_dir_q, out_aux_q, out_run_q;

  logic                   advance;
  logic                   accept;
  logic signed [DutyWidth-1:0] duty;
  logic signed [DutyWidth-1:0] duty_sat;
  logic [MagWidth-1:0]    mag;
  logic [MagWidth-1:0]    brake_mag;
  logic [MagWidth-1:0]    mag_sel;
  logic                   fwd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= '0;
      reverse_q     <= 1'b0;
      brake_en_q    <= 1'b0;
      brake_duty_q  <= '0;
      pins_q        <= '0;
      aux_present_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PERIOD:      period_q      <= cfg_data_i[PeriodWidth-1:0];
        CFG_REVERSE:     reverse_q     <= cfg_data_i[0];
        CFG_BRAKE_EN:    brake_en_q    <= cfg_data_i[0];
        CFG_BRAKE_DUTY:  brake_duty_q  <= cfg_data_i[MagWidth-1:0];
        CFG_PIN_LEVELS:  pins_q        <= cfg_data_i[PinWidth-1:0];
        CFG_AUX_PRESENT: aux_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign duty = signed'(s_axis_tdata[DutyWidth-1:0]);

  always_comb begin
    if (duty > signed'(DutyWidth'(DutyFull))) begin
      duty_sat = DutyWidth'(DutyFull);
    end else if (duty < -signed'(DutyWidth'(DutyFull))) begin
      duty_sat = -signed'(DutyWidth'(DutyFull));
    end else begin
      duty_sat = duty;
    end
  end

  assign mag       = duty_sat[DutyWidth-1] ? MagWidth'(-duty_sat) : MagWidth'(duty_sat);
  assign fwd       = !duty_sat[DutyWidth-1] ^ reverse_q;
  assign brake_mag = (brake_duty_q > MagWidth'(DutyFull)) ? MagWidth'(DutyFull)
                                                          : brake_duty_q;

  always_comb begin
    dir_d   = dir_q;
    aux_d   = aux_q;
    run_d   = run_q;
    mag_sel = '0;
    s1_req_d.act = CMP_HOLD;
    unique case (s_axis_tuser)
      OP_INIT: begin
        dir_d = pins_q[PinDirFwd];
        if (aux_present_q) begin
          aux_d = pins_q[PinAuxFwd];
        end
        run_d = 1'b1;
        s1_req_d.act = CMP_ZERO;
      end
      OP_SET_DUTY: begin
        if (duty_sat == '0) begin
          s1_req_d.act = CMP_ZERO;
        end else begin
          dir_d = fwd ? pins_q[PinDirFwd] : pins_q[PinDirRev];
          if (aux_present_q) begin
            aux_d = fwd ? pins_q[PinAuxFwd] : pins_q[PinAuxRev];
          end
          mag_sel      = mag;
          s1_req_d.act = CMP_LOAD;
        end
      end
      OP_STOP: begin
        if (brake_en_q) begin
          dir_d = pins_q[PinDirBrake];
          if (aux_present_q) begin
            aux_d = pins_q[PinAuxBrake];
          end
          mag_sel      = brake_mag;
          s1_req_d.act = CMP_LOAD;
        end else begin
          s1_req_d.act = CMP_ZERO;
        end
      end
      default: ;
    endcase
    s1_req_d.scaled = ProdWidth'(mag_sel) * ProdWidth'(period_q) + ProdWidth'(RoundHalf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= 1'b0;
      aux_q      <= 1'b0;
      run_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        dir_q <= dir_d;
        aux_q <= aux_d;
        run_q <= run_d;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= s1_req_d;
      s1_dir_q <= dir_d;
      s1_aux_q <= aux_d;
      s1_run_q <= run_d;
    end
  end

  dcmd_compare_scale u_scale (
    .req_i     (s1_req_q),
    .period_i  (period_q),
    .held_i    (cmp_q),
    .compare_o (cmp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cmp_q       <= '0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        cmp_q <= cmp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_dir_q <= s1_dir_q;
      out_aux_q <= s1_aux_q;
      out_run_q <= s1_run_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_run_q, out_aux_q, out_dir_q, cmp_q};

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DC motor duty and direction unit testbench
// Sends init, set-duty, stop and undefined commands over the slave stream,
// keeps its own model of the held pin levels, compare count and PWM enable,
// and checks every result on the master stream against it. Registers change
// only while the unit is idle, across directed and random settings, with
// random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
  import dcmd_pkg::*;

  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned RandomPhases  = 9;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ReportLimit   = 10;
  localparam int          DutyLimit     = DutyFull;

  localparam logic [1:0]             OpUndefined = 2'd3;
  localparam logic [CfgIdxWidth-1:0] CfgUnused   = 3'd7;

  typedef struct packed {
    logic [15:0] compare;
    logic        dir_level;
    logic        aux_level;
    logic        pwm_enabled;
  } motor_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [15:0]             s_axis_tdata;
  logic [1:0]              s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [23:0]             m_axis_tdata;

  logic [15:0] cfg_period      = '0;
  logic        cfg_reverse     = 1'b0;
  logic        cfg_brake_en    = 1'b0;
  logic [13:0] cfg_brake_duty  = '0;
  logic [5:0]  cfg_pins        = '0;
  logic        cfg_aux_present = 1'b0;

  logic        held_dir     = 1'b0;
  logic        held_aux     = 1'b0;
  logic        pwm_on       = 1'b0;
  logic [15:0] held_compare = '0;

  motor_result_t pending_results[$];

  bit          send_idle      = 1'b0;
  bit          recv_idle      = 1'b0;
  int unsigned command_count  = 0;
  int unsigned result_count   = 0;
  int unsigned write_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  dc_motor_duty_direction_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("dc_motor_duty_direction_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] duty_compare(int unsigned mag);
    logic [63:0] scaled;
    if (mag > DutyFull) mag = DutyFull;
    scaled = (64'(mag) * 64'(cfg_period) + 64'(RoundHalf)) / 64'(DutyFull);
    if (scaled > 64'(cfg_period)) scaled = 64'(cfg_period);
    return scaled[15:0];
  endfunction

  function automatic void drive_pins(int unsigned dir_bit, int unsigned aux_bit);
    held_dir = cfg_pins[dir_bit];
    if (cfg_aux_present) held_aux = cfg_pins[aux_bit];
  endfunction

  function automatic motor_result_t predict_command(logic [1:0] op,
                                                    logic signed [14:0] duty);
    int            level;
    int unsigned   mag;
    logic          forward;
    motor_result_t res;
    level = int'(duty);
    case (op)
      OP_INIT: begin
        held_compare = '0;
        drive_pins(PinDirFwd, PinAuxFwd);
        pwm_on = 1'b1;
      end
      OP_SET_DUTY: begin
        if (level > DutyLimit) level = DutyLimit;
        if (level < -DutyLimit) level = -DutyLimit;
        if (level == 0) begin
          held_compare = '0;
        end else begin
          forward = level > 0;
          mag = forward ? level : -level;
          if (cfg_reverse) forward = !forward;
          if (forward) drive_pins(PinDirFwd, PinAuxFwd);
          else drive_pins(PinDirRev, PinAuxRev);
          held_compare = duty_compare(mag);
        end
      end
      OP_STOP: begin
        if (cfg_brake_en) begin
          drive_pins(PinDirBrake, PinAuxBrake);
          held_compare = duty_compare(32'(cfg_brake_duty));
        end else begin
          held_compare = '0;
        end
      end
      default: ;
    endcase
    res.compare     = held_compare;
    res.dir_level   = held_dir;
    res.aux_level   = held_aux;
    res.pwm_enabled = pwm_on;
    return res;
  endfunction

  function automatic void check_result(logic [23:0] word);
    motor_result_t got;
    motor_result_t want;
    got.compare     = word[15:0];
    got.dir_level   = word[16];
    got.aux_level   = word[17];
    got.pwm_enabled = word[18];
    result_count++;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("Unexpected result: compare=%0d dir=%0b aux=%0b pwm=%0b",
                 got.compare, got.dir_level, got.aux_level, got.pwm_enabled);
    end else begin
      want = pending_results.pop_front();
      if (got != want) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("Result %0d: expected compare=%0d dir=%0b aux=%0b pwm=%0b, %s%0d %s%0b %s%0b %s%0b",
                   result_count, want.compare, want.dir_level, want.aux_level,
                   want.pwm_enabled, "got compare=", got.compare, "dir=",
                   got.dir_level, "aux=", got.aux_level, "pwm=", got.pwm_enabled);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_command(input logic [1:0] op, input logic signed [14:0] duty);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, duty};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_command(op, duty));
    command_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PERIOD:      cfg_period      = data;
      CFG_REVERSE:     cfg_reverse     = data[0];
      CFG_BRAKE_EN:    cfg_brake_en    = data[0];
      CFG_BRAKE_DUTY:  cfg_brake_duty  = data[13:0];
      CFG_PIN_LEVELS:  cfg_pins        = data[5:0];
      CFG_AUX_PRESENT: cfg_aux_present = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    write_count++;
  endtask

  // Commands ahead of init must act normally while the enable stays low.
  task automatic test_before_init();
    send_command(OP_SET_DUTY, 15'sd10000);
    send_command(OP_STOP, '0);
    send_command(OpUndefined, 15'sd1234);
    wait_idle();
    write_register(CFG_PERIOD, 16'd2000);
    write_register(CFG_PIN_LEVELS, 16'b011010);
    write_register(CFG_AUX_PRESENT, 16'd1);
    write_register(CFG_BRAKE_EN, 16'd1);
    write_register(CFG_BRAKE_DUTY, 16'd2500);
    send_command(OP_SET_DUTY, -15'sd2500);
    send_command(OP_STOP, '0);
    wait_idle();
  endtask

  // Full-scale period with duty and brake duty at and beyond their limits.
  task automatic test_full_scale();
    write_register(CFG_PERIOD, 16'hFFFF);
    write_register(CFG_REVERSE, 16'd0);
    write_register(CFG_BRAKE_DUTY, 16'h3FFF);
    write_register(CFG_PIN_LEVELS, 16'b100101);
    send_command(OP_INIT, '0);
    send_command(OP_SET_DUTY, 15'sd10000);
    send_command(OP_SET_DUTY, -15'sd10000);
    send_command(OP_SET_DUTY, 15'h3FFF);
    send_command(OP_SET_DUTY, 15'h4000);
    send_command(OP_SET_DUTY, '0);
    send_command(OP_SET_DUTY, 15'sd1);
    send_command(OP_SET_DUTY, -15'sd1);
    send_command(OP_STOP, '0);
    send_command(OpUndefined, 15'h7FFF);
    send_command(OP_SET_DUTY, 15'sd5000);
    wait_idle();
  endtask

  // Reversed sense, coasting stop, no aux pin, and rounding at a period of one.
  task automatic test_reverse_and_coast();
    write_register(CFG_REVERSE, 16'd1);
    write_register(CFG_BRAKE_EN, 16'd0);
    write_register(CFG_AUX_PRESENT, 16'd0);
    write_register(CFG_PIN_LEVELS, 16'b000110);
    write_register(CFG_PERIOD, 16'd1);
    write_register(CfgUnused, 16'hFFFF);
    send_command(OP_SET_DUTY, 15'sd5000);
    send_command(OP_SET_DUTY, 15'sd4999);
    send_command(OP_SET_DUTY, -15'sd3);
    send_command(OP_STOP, '0);
    send_command(OP_INIT, '0);
    wait_idle();
  endtask

  task automatic randomize_registers(input int phase);
    logic [15:0] period_value;
    case (phase)
      0: period_value = 16'hFFFF;
      1: period_value = 16'd0;
      2: period_value = 16'd1;
      3: period_value = 16'($urandom_range(2, 200));
      default: period_value = 16'($urandom_range(0, 65535));
    endcase
    write_register(CFG_PERIOD, period_value);
    write_register(CFG_REVERSE, 16'($urandom_range(0, 65535)));
    write_register(CFG_BRAKE_EN, 16'($urandom_range(0, 65535)));
    if ($urandom_range(0, 1) == 0)
      write_register(CFG_BRAKE_DUTY, 16'($urandom_range(0, DutyFull)));
    else
      write_register(CFG_BRAKE_DUTY, 16'($urandom_range(0, 65535)));
    write_register(CFG_PIN_LEVELS, 16'($urandom_range(0, 65535)));
    write_register(CFG_AUX_PRESENT, 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_command();
    int unsigned      pick;
    logic [1:0]       op;
    logic signed [14:0] duty;
    pick = $urandom_range(0, 99);
    if (pick < 15) op = OP_INIT;
    else if (pick < 70) op = OP_SET_DUTY;
    else if (pick < 90) op = OP_STOP;
    else op = OpUndefined;
    case ($urandom_range(0, 9))
      0: duty = $urandom_range(0, 1) ? 15'(DutyLimit) : 15'(-DutyLimit);
      1: duty = '0;
      2: duty = 15'($urandom_range(0, 32767));
      3: duty = $urandom_range(0, 1) ? 15'($urandom_range(0, 20))
                                      : 15'(-int'($urandom_range(0, 20)));
      default: duty = 15'(int'($urandom_range(0, 20000)) - DutyLimit);
    endcase
    send_command(op, duty);
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      randomize_registers(phase);
      send_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
      recv_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < ItemsPerPhase; n++) send_random_command();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_init();
    test_full_scale();
    test_reverse_and_coast();
    test_random_phases();
    wait_idle();

    $display("Sent %0d motor commands and checked %0d results over %0d register writes,",
             command_count, result_count, write_count);
    $display("including %0d random register settings with stream gaps and stalls.",
             RandomPhases);
    if (mismatch_count == 0) begin
      $display("dc_motor_duty_direction_unit: match");
    end else begin
      $display("%0d results differed from the prediction.", mismatch_count);
      $display("dc_motor_duty_direction_unit: mismatch");
    end
    $finish;
  end

endmodule
